FILE: sv/chs_pkg.sv
package chs_pkg;

  localparam int KEY_W     = 31;
  localparam int CFG_W     = 5;
  localparam int STATUS_W  = 3;
  localparam int DIV_CNT_W = $clog2(KEY_W + 1);

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 5'd10;
  localparam logic [1:0]       ADDR_BUCKET_COUNT  = 2'd0;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CMP,
    S_FIN
  } state_t;

  // slot store commands, one beat per cycle
  typedef struct packed {
    logic rd;
    logic wr_key;
    logic kill;
    logic clr_all;
  } slot_req_t;

endpackage

FILE: sv/chs_rem.sv
module chs_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [chs_pkg::KEY_W-1:0]   dividend,
  input  logic [chs_pkg::CFG_W-1:0]   divisor,
  output logic                        done,
  output logic [chs_pkg::CFG_W-1:0]   rem
);

  logic                             busy_r;
  logic [chs_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [chs_pkg::KEY_W-1:0]        key_sh_r;
  logic [chs_pkg::CFG_W-1:0]        div_r;
  logic [chs_pkg::CFG_W-1:0]        rem_r;
  logic [chs_pkg::CFG_W:0]          partial;
  logic [chs_pkg::CFG_W:0]          diff;
  logic                             ge;

  // restoring remainder, one dividend bit per cycle
  assign partial = {rem_r, key_sh_r[chs_pkg::KEY_W-1]};
  assign ge      = partial >= {1'b0, div_r};
  assign diff    = partial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= chs_pkg::DIV_CNT_W'(chs_pkg::KEY_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == chs_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_sh_r <= dividend;
      div_r    <= divisor;
      rem_r    <= '0;
    end else if (busy_r) begin
      key_sh_r <= {key_sh_r[chs_pkg::KEY_W-2:0], 1'b0};
      rem_r    <= ge ? diff[chs_pkg::CFG_W-1:0] : partial[chs_pkg::CFG_W-1:0];
    end
  end

  assign done = busy_r && (cnt_r == chs_pkg::DIV_CNT_W'(1));
  assign rem  = rem_r;

endmodule

FILE: sv/chs_slots.sv
module chs_slots #(
  parameter int SLOT_COUNT = 64,
  parameter int SLOT_AW    = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chs_pkg::slot_req_t         req,
  input  logic [SLOT_AW-1:0]         addr,
  input  logic [chs_pkg::KEY_W-1:0]  wkey,
  output logic [chs_pkg::KEY_W-1:0]  rd_key,
  output logic                       rd_vld
);

  logic [chs_pkg::KEY_W-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]     vld_r;
  logic [chs_pkg::KEY_W-1:0] rd_key_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_key) begin
      mem[addr] <= wkey;
    end
    if (req.rd) begin
      rd_key_r <= mem[addr];
      rd_vld_r <= vld_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr_all) begin
      vld_r <= '0;
    end else if (req.wr_key) begin
      vld_r[addr] <= 1'b1;
    end else if (req.kill) begin
      vld_r[addr] <= 1'b0;
    end
  end

  assign rd_key = rd_key_r;
  assign rd_vld = rd_vld_r;

endmodule

FILE: sv/chained_hash_set.sv
// Set of unique 31-bit keys in a bucketed hash table: bucket = key mod the
// effective bucket count (0 reads as 1, values above MAX_BUCKETS saturate),
// each bucket holding BUCKET_WAYS slots. Modes: insert, search, delete, clear
// all. Every request gives one status beat. A clear goes from accept straight
// to commit; any other request runs the bit-serial remainder unit, then one
// read and one compare per way through the registered key memory port,
// stopping at the first match, then commits. The commit waits while the
// previous status is still unread; the block is ready again in the cycle
// after it, and takes no new request before then. A finished status waits in
// an output register while the next request is taken. Stored keys are not
// rehashed when bucket_count changes.
module chained_hash_set #(
  parameter int MAX_BUCKETS = 16,
  parameter int BUCKET_WAYS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [chs_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [chs_pkg::STATUS_W-1:0]  out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int SLOT_COUNT = MAX_BUCKETS * BUCKET_WAYS;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WAY_W      = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

  chs_pkg::state_t              state_r, state_nxt;
  chs_pkg::mode_t               mode_r;
  logic [chs_pkg::KEY_W-1:0]    key_r;
  logic [chs_pkg::CFG_W-1:0]    bc_r;
  logic [chs_pkg::CFG_W-1:0]    eff;
  logic [WAY_W-1:0]             way_r;
  logic [WAY_W-1:0]             free_way_r;
  logic                         free_found_r;
  logic                         hit_r;
  logic                         out_valid_r;
  chs_pkg::status_t             status_r;
  chs_pkg::status_t             status_c;

  logic                         accept;
  logic                         fin_go;
  logic                         last_way;
  logic                         match;
  logic                         div_start;
  logic                         div_done;
  logic [chs_pkg::CFG_W-1:0]    rem;
  logic [WAY_W-1:0]             way_sel;
  logic [SLOT_AW-1:0]           slot_addr;
  chs_pkg::slot_req_t           slot_req;
  logic [chs_pkg::KEY_W-1:0]    rd_key;
  logic                         rd_vld;

  // config register
  assign pready = 1'b1;
  assign prdata = {{(32 - chs_pkg::CFG_W){1'b0}}, bc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= chs_pkg::BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == chs_pkg::ADDR_BUCKET_COUNT) begin
      bc_r <= pwdata[chs_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (bc_r == '0) begin
      eff = chs_pkg::CFG_W'(1);
    end else if (32'(bc_r) > MAX_BUCKETS) begin
      eff = chs_pkg::CFG_W'(MAX_BUCKETS);
    end else begin
      eff = bc_r;
    end
  end

  assign accept   = in_valid && in_ready;
  assign fin_go   = !out_valid_r || out_ready;
  assign last_way = way_r == WAY_W'(BUCKET_WAYS - 1);
  assign match    = rd_vld && (rd_key == key_r);
  assign way_sel  = (state_r == chs_pkg::S_FIN && !hit_r) ? free_way_r : way_r;
  assign slot_addr = SLOT_AW'(SLOT_AW'(rem) * SLOT_AW'(BUCKET_WAYS) + SLOT_AW'(way_sel));

  // started on the accepting edge, so the key comes straight from the port
  chs_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_key),
    .divisor  (eff),
    .done     (div_done),
    .rem      (rem)
  );

  chs_slots #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_AW    (SLOT_AW)
  ) u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (slot_req),
    .addr   (slot_addr),
    .wkey   (key_r),
    .rd_key (rd_key),
    .rd_vld (rd_vld)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chs_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (chs_pkg::mode_t'(in_mode) == chs_pkg::MODE_CLEAR) ?
                      chs_pkg::S_FIN : chs_pkg::S_DIV;
        end
      end
      chs_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = chs_pkg::S_RD;
        end
      end
      chs_pkg::S_RD:  state_nxt = chs_pkg::S_CMP;
      chs_pkg::S_CMP: state_nxt = (match || last_way) ? chs_pkg::S_FIN : chs_pkg::S_RD;
      chs_pkg::S_FIN: begin
        if (fin_go) begin
          state_nxt = chs_pkg::S_IDLE;
        end
      end
      default: state_nxt = chs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    slot_req  = '0;
    status_c  = chs_pkg::ST_NOT_FOUND;
    unique case (state_r)
      chs_pkg::S_IDLE: in_ready = 1'b1;
      chs_pkg::S_DIV: begin
      end
      chs_pkg::S_RD:  slot_req.rd = 1'b1;
      chs_pkg::S_CMP: begin
      end
      chs_pkg::S_FIN: begin
        unique case (mode_r)
          chs_pkg::MODE_CLEAR: begin
            status_c = chs_pkg::ST_CLEARED;
            slot_req.clr_all = fin_go;
          end
          chs_pkg::MODE_INSERT: begin
            if (hit_r) begin
              status_c = chs_pkg::ST_EXISTS;
            end else if (free_found_r) begin
              status_c = chs_pkg::ST_INSERTED;
              slot_req.wr_key = fin_go;
            end else begin
              status_c = chs_pkg::ST_FULL;
            end
          end
          chs_pkg::MODE_SEARCH: begin
            status_c = hit_r ? chs_pkg::ST_FOUND : chs_pkg::ST_NOT_FOUND;
          end
          chs_pkg::MODE_DELETE: begin
            status_c = hit_r ? chs_pkg::ST_DELETED : chs_pkg::ST_NOT_FOUND;
            slot_req.kill = fin_go && hit_r;
          end
          default: status_c = chs_pkg::ST_NOT_FOUND;
        endcase
      end
      default: begin
      end
    endcase
    if (state_r == chs_pkg::S_IDLE && accept &&
        chs_pkg::mode_t'(in_mode) != chs_pkg::MODE_CLEAR) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == chs_pkg::S_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= chs_pkg::mode_t'(in_mode);
      key_r  <= in_key;
    end
    if (state_r == chs_pkg::S_DIV) begin
      way_r        <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == chs_pkg::S_CMP) begin
      if (match) begin
        hit_r <= 1'b1;
      end else begin
        if (!rd_vld && !free_found_r) begin
          free_found_r <= 1'b1;
          free_way_r   <= way_r;
        end
        if (!last_way) begin
          way_r <= way_r + 1'b1;
        end
      end
    end
    if (state_r == chs_pkg::S_FIN && fin_go) begin
      status_r <= status_c;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == chs_pkg::S_DIV)
    else $error("remainder done outside division");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chs_pkg::S_DIV && div_done) |=> rem < eff)
    else $error("remainder not below bucket count");

  a_write_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    slot_req.wr_key |-> (!hit_r && free_found_r && mode_r == chs_pkg::MODE_INSERT))
    else $error("slot write without free way");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == chs_pkg::S_CMP |-> $past(state_r) == chs_pkg::S_RD)
    else $error("compare without read");

  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && chs_pkg::mode_t'(in_mode) == chs_pkg::MODE_CLEAR) |=>
      state_r == chs_pkg::S_FIN)
    else $error("clear did not go to commit");
`endif

endmodule
